// ----- src/servo_status_packet_parser_core_assert.svh -----
// Assertion macros used by the checker file.
// Every macro expects signals named clk and rst in the scope where it is used.
`ifndef SERVO_STATUS_PACKET_PARSER_CORE_ASSERT_SVH
`define SERVO_STATUS_PACKET_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define SSP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssp implication check failed");

// Next-cycle implication, ignored while reset is high.
`define SSP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssp next-cycle check failed");

// Implication that is checked through reset as well.
`define SSP_ASSERT_ALL(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("ssp reset check failed");

`endif

// ----- src/ssp_pkg.sv -----
`timescale 1ns / 1ps
package ssp_pkg;

  localparam logic [7:0] HEADER_BYTE  = 8'hFF;
  localparam int         LEN_BIAS     = 2;
  localparam int         BODY_MAX_DEF = 4;
  localparam int         BODY_SLOTS   = 3;

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_ID,
    PH_LEN,
    PH_BODY,
    PH_CHECK
  } phase_t;

  typedef struct packed {
    logic [7:0]                 servo_id;
    logic [BODY_SLOTS-1:0][7:0] body;
    logic [1:0]                 body_count;
  } result_t;

endpackage

// ----- src/ssp_in_reg.sv -----
`timescale 1ns / 1ps
module ssp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       q_valid,
  output logic [7:0] q_byte
);

  // hold the beat until the parser consumes it
  assign in_stall = q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      q_byte <= rx_byte;
    end
  end

endmodule

// ----- src/ssp_parser.sv -----
`timescale 1ns / 1ps
module ssp_parser #(
  parameter int BODY_MAX = ssp_pkg::BODY_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      rx_data,
  output logic            hit,
  output ssp_pkg::result_t result
);

  localparam int EBW       = $clog2(BODY_MAX);
  localparam int LEN_LIMIT = ssp_pkg::LEN_BIAS + BODY_MAX;
  localparam int SLOTS     = ssp_pkg::BODY_SLOTS;

  ssp_pkg::phase_t phase;
  ssp_pkg::phase_t phase_next;
  logic [7:0]      packet_id;
  logic [EBW-1:0]  expected_body;
  logic [EBW-1:0]  body_index;
  logic [EBW-1:0]  index_inc;
  logic [7:0]      running_sum;
  logic [7:0]      body_store [SLOTS];
  logic            len_ok;
  logic            is_header;
  logic            sum_match;

  assign is_header = (rx_data == ssp_pkg::HEADER_BYTE);
  assign len_ok    = (rx_data >= 8'(ssp_pkg::LEN_BIAS)) && (rx_data < 8'(LEN_LIMIT));
  assign sum_match = (rx_data == ~running_sum);
  assign index_inc = EBW'(body_index + 1'b1);

  // next state
  always_comb begin
    phase_next = phase;
    case (phase)
      ssp_pkg::PH_HUNT1: begin
        if (is_header) phase_next = ssp_pkg::PH_HUNT2;
      end
      ssp_pkg::PH_HUNT2: begin
        phase_next = is_header ? ssp_pkg::PH_ID : ssp_pkg::PH_HUNT1;
      end
      ssp_pkg::PH_ID: begin
        phase_next = ssp_pkg::PH_LEN;
      end
      ssp_pkg::PH_LEN: begin
        if (!len_ok) begin
          phase_next = ssp_pkg::PH_HUNT1;
        end else if (rx_data == 8'(ssp_pkg::LEN_BIAS)) begin
          phase_next = ssp_pkg::PH_CHECK;
        end else begin
          phase_next = ssp_pkg::PH_BODY;
        end
      end
      ssp_pkg::PH_BODY: begin
        if (index_inc >= expected_body) phase_next = ssp_pkg::PH_CHECK;
      end
      ssp_pkg::PH_CHECK: begin
        phase_next = ssp_pkg::PH_HUNT1;
      end
      default: begin
        phase_next = ssp_pkg::PH_HUNT1;
      end
    endcase
  end

  // outputs: result on a matching checksum, absent body bytes read as zero
  always_comb begin
    hit               = 1'b0;
    result.servo_id   = packet_id;
    result.body_count = 2'(expected_body);
    for (int k = 0; k < SLOTS; k++) begin
      result.body[k] = ({2'b00, expected_body} > (EBW+2)'(k)) ? body_store[k] : 8'h00;
    end
    case (phase)
      ssp_pkg::PH_CHECK: hit = sum_match;
      default:           hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ssp_pkg::PH_HUNT1;
      packet_id     <= '0;
      expected_body <= '0;
      body_index    <= '0;
      running_sum   <= '0;
    end else if (step) begin
      phase <= phase_next;
      case (phase)
        ssp_pkg::PH_ID: begin
          packet_id <= rx_data;
        end
        ssp_pkg::PH_LEN: begin
          if (len_ok) begin
            expected_body <= EBW'(rx_data - 8'(ssp_pkg::LEN_BIAS));
            body_index    <= '0;
            running_sum   <= packet_id + rx_data;
          end
        end
        ssp_pkg::PH_BODY: begin
          body_index  <= index_inc;
          running_sum <= running_sum + rx_data;
        end
        default: begin
        end
      endcase
    end
  end

  // only the first few body bytes leave the block, keep just those
  for (genvar k = 0; k < SLOTS; k++) begin : g_store
    always_ff @(posedge clk) begin
      if (step && (phase == ssp_pkg::PH_BODY) &&
          ({2'b00, body_index} == (EBW+2)'(k))) begin
        body_store[k] <= rx_data;
      end
    end
  end

endmodule

// ----- src/ssp_out_reg.sv -----
`timescale 1ns / 1ps
module ssp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ssp_pkg::result_t result,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       servo_id,
  output logic [7:0]       body_first,
  output logic [7:0]       body_second,
  output logic [7:0]       body_third,
  output logic [1:0]       body_count
);

  ssp_pkg::result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign servo_id    = held.servo_id;
  assign body_first  = held.body[0];
  assign body_second = held.body[1];
  assign body_third  = held.body[2];
  assign body_count  = held.body_count;

endmodule

// ----- src/servo_status_packet_parser_core.sv -----
`timescale 1ns / 1ps
// Status packet parser for a half-duplex serial servo bus. Feed it received
// bytes, one beat per byte; it finds two 0xFF header bytes, the id, the length
// byte L (taken only when 2 <= L < 2+BODY_MAX), L-2 body bytes and the
// checksum, and emits one result beat per packet whose checksum equals the
// inverted 8-bit sum of id, L and body. Bad lengths and bad checksums drop
// the packet silently and the parser hunts for a new header. It takes one
// byte every cycle; a result beat is offered after the checksum byte has
// passed the input register and the result register has loaded it. Only
// a checksum byte that completes a packet can be held up, and only while
// the previous result still sits unclaimed in the result register.

module servo_status_packet_parser_core #(
  parameter int BODY_MAX = ssp_pkg::BODY_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] servo_id,
  output logic [7:0] body_first,
  output logic [7:0] body_second,
  output logic [7:0] body_third,
  output logic [1:0] body_count
);

  logic             q_valid;
  logic [7:0]       q_byte;
  logic             hit;
  logic             advance;
  ssp_pkg::result_t result;

  // Input register: one byte waits here while the parser looks at it.
  ssp_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_byte   (q_byte)
  );

  // Advance the parser on every held byte, except a byte that finishes a
  // packet while the result register is still full and stalled.
  assign advance = q_valid && (!hit || !out_valid || !out_stall);

  // Parser: phase machine, running checksum and the body byte slots.
  ssp_parser #(
    .BODY_MAX (BODY_MAX)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_data (q_byte),
    .hit     (hit),
    .result  (result)
  );

  // Result register: load a good packet, drop valid once the beat is taken.
  ssp_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && hit),
    .result      (result),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .servo_id    (servo_id),
    .body_first  (body_first),
    .body_second (body_second),
    .body_third  (body_third),
    .body_count  (body_count)
  );

endmodule

// ----- src/ssp_checker.sv -----
`timescale 1ns / 1ps
`include "servo_status_packet_parser_core_assert.svh"

module ssp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] servo_id,
  input logic [7:0] body_first,
  input logic [7:0] body_second,
  input logic [7:0] body_third,
  input logic [1:0] body_count
);

  // a stalled result beat keeps its id, first body byte and count
  `SSP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(servo_id) && $stable(body_first) && $stable(body_count))

  // body bytes beyond the count read as zero
  `SSP_ASSERT_IMP(a_third_zero, out_valid && (body_count != 2'd3), body_third == 8'h00)
  `SSP_ASSERT_IMP(a_second_zero, out_valid && ((body_count == 2'd0) || (body_count == 2'd1)), body_second == 8'h00)
  `SSP_ASSERT_IMP(a_first_zero, out_valid && (body_count == 2'd0), body_first == 8'h00)

  // no packet can complete in the cycle right after reset
  `SSP_ASSERT_ALL(a_reset_quiet, $past(rst) && !rst, !out_valid)

endmodule

bind servo_status_packet_parser_core ssp_checker u_ssp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .servo_id    (servo_id),
  .body_first  (body_first),
  .body_second (body_second),
  .body_third  (body_third),
  .body_count  (body_count)
);
